### rtl/assert_macros.svh
// assertion macros shared by the coulomb counter rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

### rtl/bcc_pkg.sv
// shared types, constants and codes of the coulomb counter
// no dependencies
`timescale 1ns / 1ps

package bcc_pkg;

  // field and datapath widths
  localparam int unsigned CUR_W    = 20;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned CHG_W    = 38;
  localparam int unsigned AMT_W    = 36;
  localparam int unsigned EPROD_W  = 52;
  localparam int unsigned ENG_W    = 64;
  localparam int unsigned TTL_W    = 40;
  localparam int unsigned SOC_W    = 17;
  localparam int unsigned VOLT_W   = 17;
  localparam int unsigned FAULT_W  = 2;
  localparam int unsigned IR_W     = 37;
  localparam int unsigned UV_W     = 38;
  localparam int unsigned UVDIV_W  = 27;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned RECIP_W  = 28;
  localparam int unsigned VPROD_W  = 54;

  // conversion constants
  localparam logic [21:0]        MAS_PER_MAH  = 22'd3600000;
  localparam logic [CHG_W-1:0]   CHARGE_RESET = 38'd3600000000;
  localparam logic [9:0]         MV_TO_UV     = 10'd1000;
  localparam logic [UVDIV_W-1:0] UV_CLAMP     = 27'd131072000;
  localparam logic [SOC_W-1:0]   SOC_FULL     = 17'd65536;
  localparam logic [VOLT_W-1:0]  VOLT_MAX     = 17'd131071;
  localparam logic [TTL_W-1:0]   TTL_INFINITE = '1;

  // microvolts to millivolts: multiply by ceil(2^37 / 1000), keep bits from 37 up
  // exact for every value below 2^27
  localparam logic [RECIP_W-1:0] UV_TO_MV_RECIP = 28'd137438954;
  localparam int unsigned        VOLT_SHIFT     = 37;

  // divider step counts per operation
  localparam logic [CNT_W-1:0] SOC_STEPS  = 6'd16;
  localparam logic [CNT_W-1:0] TTL_STEPS  = 6'd38;

  // register reset values
  localparam logic [REG_W-1:0] CAPACITY_RESET   = 16'd1000;
  localparam logic [REG_W-1:0] OPEN_MV_RESET    = 16'd5000;
  localparam logic [REG_W-1:0] RESISTANCE_RESET = 16'd0;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_MV    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESISTANCE = 2'd2;

  // status codes
  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd2;

  // divider operations
  typedef enum logic [1:0] {
    DIV_SOC,
    DIV_TTL
  } div_op_e;

  typedef struct packed {
    logic signed [CUR_W-1:0] port_current_ma;
    logic [MS_W-1:0]         elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [SOC_W-1:0]        soc_q16;
    logic [CHG_W-1:0]        remaining_charge;
    logic signed [ENG_W-1:0] energy_used;
    logic [TTL_W-1:0]        time_to_limit_ms;
    logic [VOLT_W-1:0]       closed_voltage_mv;
    logic [FAULT_W-1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] capacity_mah;
    logic [REG_W-1:0] open_circuit_mv;
    logic [REG_W-1:0] resistance_mohm;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch_in;
    logic    mul;
    logic    update;
    logic    energy;
    logic    div_start;
    div_op_e div_op;
    logic    cap_soc;
    logic    cap_ttl;
    logic    cap_volt;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_status_t;

endpackage

### rtl/bcc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on bcc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bcc_pkg::CHG_W-1:0]  init_rem_i,
  input  logic [bcc_pkg::CHG_W-1:0]  numer_i,
  input  logic [bcc_pkg::CHG_W-1:0]  divisor_i,
  input  logic [bcc_pkg::CNT_W-1:0]  steps_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [bcc_pkg::CHG_W-1:0]  quotient_o
);
  import bcc_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CHG_W-1:0] rem_q, rem_d;
  logic [CHG_W-1:0] num_q, num_d;
  logic [CHG_W-1:0] quo_q, quo_d;
  logic [CHG_W-1:0] div_q, div_d;
  logic [CHG_W:0]   trial;
  logic             fits;

  // one trial subtraction per step
  assign trial = {rem_q, num_q[CHG_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = init_rem_i;
      num_d  = numer_i;
      quo_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? CHG_W'(trial - {1'b0, div_q}) : trial[CHG_W-1:0];
      num_d = {num_q[CHG_W-2:0], 1'b0};
      quo_d = {quo_q[CHG_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `ASSERT_CLK(a_done_pulse, done_q |=> !done_q)
  `ASSERT_CLK(a_start_idle, start_i |-> !busy_q)
  `ASSERT_CLK(a_done_after_busy, done_q |-> ($past(busy_q) && !busy_q))

endmodule

### rtl/bcc_ctrl.sv
// sequencing state machine of the coulomb counter
// depends on bcc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  bcc_pkg::dp_status_t   status_i,
  output bcc_pkg::dp_cmd_t      cmd_o
);
  import bcc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_ENG   = 3'd3;
  localparam logic [2:0] ST_DSOC  = 3'd4;
  localparam logic [2:0] ST_DTTL  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;
  logic       out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d = ST_ENG;
      end
      ST_ENG: begin
        cmd_o.energy    = 1'b1;
        cmd_o.cap_volt  = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_SOC;
        state_d = ST_DSOC;
      end
      ST_DSOC: begin
        if (status_i.div_done) begin
          cmd_o.cap_soc   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_TTL;
          state_d = ST_DTTL;
        end
      end
      ST_DTTL: begin
        if (status_i.div_done) begin
          cmd_o.cap_ttl = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid tracks the result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_busy_after_take, in_take |=> in_stall_o)
  `ASSERT_NEVER(a_start_while_busy, cmd_o.div_start && status_i.div_busy)
  `ASSERT_CLK(a_valid_after_load, cmd_o.out_load |=> out_valid_o)
  `ASSERT_NEVER(a_load_over_result, cmd_o.out_load && out_valid_q && out_stall_i)

endmodule

### rtl/bcc_datapath.sv
// charge, energy and result datapath of the coulomb counter
// depends on bcc_pkg, bcc_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bcc_pkg::in_item_t    in_data_i,
  input  bcc_pkg::cfg_t        cfg_i,
  input  bcc_pkg::dp_cmd_t     cmd_i,
  output bcc_pkg::dp_status_t  status_o,
  output bcc_pkg::out_item_t   out_data_o
);
  import bcc_pkg::*;

  // latched transaction
  logic signed [CUR_W-1:0] cur_q;
  logic [CUR_W-1:0]        mag_q, mag_d;
  logic [MS_W-1:0]         ms_q;
  logic                    cur_neg, cur_zero, cur_pos;

  // products
  logic [AMT_W-1:0]        amount_q, amount_d;
  logic [CHG_W-1:0]        full_q, full_d;
  logic signed [IR_W-1:0]  ir_q, ir_d;
  logic [EPROD_W-1:0]      eprod_q, eprod_d;
  logic [25:0]             ocv_uv;
  logic signed [UV_W-1:0]  uv_d;
  logic [UVDIV_W-1:0]      uv_q;
  logic                    uv_neg_q, uv_big_q;
  logic [VPROD_W-1:0]      volt_prod;

  // architectural state
  logic [CHG_W-1:0]        stored_q, stored_d;
  logic [ENG_W-1:0]        energy_q, energy_d;
  logic [FAULT_W-1:0]      fault_q, fault_d;
  logic [CHG_W:0]          charge_sum;

  // results
  logic [SOC_W-1:0]        soc_res_q;
  logic [TTL_W-1:0]        ttl_res_q;
  logic [VOLT_W-1:0]       volt_res_q;
  out_item_t               out_q;

  // divider operands
  logic [CHG_W-1:0]        div_rem, div_num, div_den, room;
  logic [CNT_W-1:0]        div_steps;
  logic [CHG_W-1:0]        quo;
  logic                    div_busy, div_done;

  assign cur_neg  = cur_q[CUR_W-1];
  assign cur_zero = (cur_q == '0);
  assign cur_pos  = !cur_neg && !cur_zero;

  // current magnitude at input
  always_comb begin
    logic [CUR_W-1:0] raw;
    raw   = in_data_i.port_current_ma;
    mag_d = raw[CUR_W-1] ? (~raw + CUR_W'(1)) : raw;
  end

  // first multiply stage
  assign amount_d = {16'b0, mag_q} * {20'b0, ms_q};
  assign full_d   = {22'b0, cfg_i.capacity_mah} * {16'b0, MAS_PER_MAH};
  assign ir_d     = IR_W'(cur_q) * IR_W'($signed({1'b0, cfg_i.resistance_mohm}));

  // second stage: energy product and loaded voltage in microvolts
  assign eprod_d = {16'b0, amount_q} * {36'b0, cfg_i.open_circuit_mv};
  assign ocv_uv  = {10'b0, cfg_i.open_circuit_mv} * {16'b0, MV_TO_UV};
  assign uv_d    = $signed({12'b0, ocv_uv}) + UV_W'(ir_q);

  // millivolts by reciprocal multiplication, product stays below 2^54
  assign volt_prod = {27'b0, uv_q} * {26'b0, UV_TO_MV_RECIP};

  // charge update with clamping and sticky status
  assign charge_sum = {1'b0, stored_q} + {3'b0, amount_q};

  always_comb begin
    stored_d = stored_q;
    fault_d  = fault_q;
    if (cmd_i.update) begin
      if (cur_neg) begin
        if ({2'b0, amount_q} >= stored_q) begin
          stored_d = '0;
          if (fault_q == FAULT_NONE) fault_d = FAULT_EMPTY;
        end else begin
          stored_d = stored_q - {2'b0, amount_q};
        end
      end else if (cur_pos) begin
        if (charge_sum > {1'b0, full_q}) begin
          stored_d = full_q;
          if (fault_q == FAULT_NONE) fault_d = FAULT_FULL;
        end else begin
          stored_d = charge_sum[CHG_W-1:0];
        end
      end
    end
  end

  // energy total wraps, always uses the requested amount
  always_comb begin
    energy_d = energy_q;
    if (cmd_i.energy) begin
      if (cur_neg) begin
        energy_d = energy_q + {12'b0, eprod_q};
      end else if (cur_pos) begin
        energy_d = energy_q - {12'b0, eprod_q};
      end
    end
  end

  // divider operand select
  assign room = (full_q > stored_q) ? (full_q - stored_q) : '0;

  always_comb begin
    div_rem   = '0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    case (cmd_i.div_op)
      DIV_SOC: begin
        div_rem   = stored_q;
        div_den   = full_q;
        div_steps = SOC_STEPS;
      end
      DIV_TTL: begin
        div_num   = cur_neg ? stored_q : room;
        div_den   = {18'b0, mag_q};
        div_steps = TTL_STEPS;
      end
      default: begin
        div_steps = '0;
      end
    endcase
  end

  bcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .init_rem_i (div_rem),
    .numer_i    (div_num),
    .divisor_i  (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= CHARGE_RESET;
      energy_q <= '0;
      fault_q  <= FAULT_NONE;
    end else begin
      stored_q <= stored_d;
      energy_q <= energy_d;
      fault_q  <= fault_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cur_q <= in_data_i.port_current_ma;
      mag_q <= mag_d;
      ms_q  <= in_data_i.elapsed_ms;
    end
    if (cmd_i.mul) begin
      amount_q <= amount_d;
      full_q   <= full_d;
      ir_q     <= ir_d;
    end
    if (cmd_i.update) begin
      eprod_q  <= eprod_d;
      uv_q     <= uv_d[UVDIV_W-1:0];
      uv_neg_q <= uv_d[UV_W-1];
      uv_big_q <= !uv_d[UV_W-1] && (uv_d[UV_W-2:0] >= (UV_W-1)'(UV_CLAMP));
    end
  end

  // result capture from the divider and the voltage product
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_soc) begin
      if (full_q == '0) begin
        soc_res_q <= '0;
      end else if (stored_q >= full_q) begin
        soc_res_q <= SOC_FULL;
      end else begin
        soc_res_q <= {1'b0, quo[15:0]};
      end
    end
    if (cmd_i.cap_ttl) begin
      ttl_res_q <= cur_zero ? TTL_INFINITE : {2'b0, quo};
    end
    if (cmd_i.cap_volt) begin
      if (uv_neg_q) begin
        volt_res_q <= '0;
      end else if (uv_big_q) begin
        volt_res_q <= VOLT_MAX;
      end else begin
        volt_res_q <= volt_prod[VOLT_SHIFT +: VOLT_W];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.soc_q16           <= soc_res_q;
      out_q.remaining_charge  <= stored_q;
      out_q.energy_used       <= energy_q;
      out_q.time_to_limit_ms  <= ttl_res_q;
      out_q.closed_voltage_mv <= volt_res_q;
      out_q.status            <= fault_q;
    end
  end

  assign out_data_o = out_q;

  `ASSERT_CLK(a_charge_clamped, (cmd_i.update && cur_pos) |=> (stored_q <= full_q))
  `ASSERT_CLK(a_fault_sticky, (fault_q != FAULT_NONE) |=> (fault_q == $past(fault_q)))

endmodule

### rtl/battery_coulomb_counter_unit.sv
// coulomb counting fuel gauge, one result transaction per input transaction
// items are handled one at a time: the input stalls until the result is loaded into the output register,
// held back by the shared restoring divider (16 + 38 quotient steps per item)
// the next input is taken while a finished result still waits at the output
// reset: asynchronous, charge full at 1000 mAh, energy and status zero, registers to defaults
`timescale 1ns / 1ps

module battery_coulomb_counter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bcc_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bcc_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bcc_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcc_pkg::REG_W-1:0]           cfg_data_i
);
  import bcc_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_mah    <= CAPACITY_RESET;
      cfg_q.open_circuit_mv <= OPEN_MV_RESET;
      cfg_q.resistance_mohm <= RESISTANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPACITY:   cfg_q.capacity_mah    <= cfg_data_i;
        REG_OPEN_MV:    cfg_q.open_circuit_mv <= cfg_data_i;
        REG_RESISTANCE: cfg_q.resistance_mohm <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

### dv/tb_battery_coulomb_counter_unit.sv
// self-checking testbench for the battery coulomb counter: directed and random steps,
// a built-in gauge predictor, and several register settings under varied idling
// depends on rtl/bcc_pkg.sv and rtl/battery_coulomb_counter_unit.sv
`timescale 1ns / 1ps

module tb_battery_coulomb_counter_unit;
  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 100;

  // clock, reset and block inputs, all known from time zero
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_idx_i   = REG_CAPACITY;
  logic [REG_W-1:0]       cfg_data_i  = '0;

  // gauge predictor state and its copy of the registers
  logic [REG_W-1:0]       cap_reg    = CAPACITY_RESET;
  logic [REG_W-1:0]       ocv_reg    = OPEN_MV_RESET;
  logic [REG_W-1:0]       res_reg    = RESISTANCE_RESET;
  logic [63:0]            charge_mas = {26'd0, CHARGE_RESET};
  logic [63:0]            energy_nj  = '0;
  logic [FAULT_W-1:0]     fault      = FAULT_NONE;

  // stimulus and expectation stores
  in_item_t               pending_steps[$];
  out_item_t              expected_readings[$];
  out_item_t              want;

  // idling controls and counters
  int                     send_idle_pct  = 10;
  int                     recv_stall_pct = 48;
  int                     hold_requests  = 0;
  int                     holds_served   = 0;
  int                     hold_left      = 0;
  int                     steps_taken    = 0;
  int                     readings_checked = 0;
  int                     mismatches     = 0;
  int                     settings_run   = 0;
  int                     cycle_count    = 0;
  bit                     empty_first;

  battery_coulomb_counter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // one time step of the gauge: update charge, energy and status, then derive the reading
  function automatic out_item_t advance_gauge(input in_item_t step);
    logic signed [63:0] cur;
    logic signed [63:0] uv;
    logic [63:0]        mag;
    logic [63:0]        amount;
    logic [63:0]        full_mas;
    logic [63:0]        next_mas;
    logic [63:0]        room;
    logic [63:0]        soc;
    logic [63:0]        ttl;
    logic [63:0]        vout;
    out_item_t          r;
    cur      = {{44{step.port_current_ma[CUR_W-1]}}, step.port_current_ma};
    mag      = (cur < 0) ? -cur : cur;
    amount   = mag * {48'd0, step.elapsed_ms};
    full_mas = {48'd0, cap_reg} * {42'd0, MAS_PER_MAH};

    // charge and energy bookkeeping, clamps set the sticky status
    if (cur < 0) begin
      if (amount >= charge_mas) begin
        charge_mas = '0;
        if (fault == FAULT_NONE) fault = FAULT_EMPTY;
      end else begin
        charge_mas = charge_mas - amount;
      end
      energy_nj = energy_nj + amount * {48'd0, ocv_reg};
    end else if (cur > 0) begin
      next_mas = charge_mas + amount;
      if (next_mas > full_mas) begin
        next_mas = full_mas;
        if (fault == FAULT_NONE) fault = FAULT_FULL;
      end
      charge_mas = {26'd0, next_mas[CHG_W-1:0]};
      energy_nj  = energy_nj - amount * {48'd0, ocv_reg};
    end

    // state of charge, clamped when capacity shrank below the stored charge
    if (full_mas == 0) begin
      soc = '0;
    end else begin
      soc = (charge_mas << 16) / full_mas;
      if (soc > {47'd0, SOC_FULL}) soc = {47'd0, SOC_FULL};
    end

    // time until empty or full
    if (cur == 0) begin
      ttl = {24'd0, TTL_INFINITE};
    end else if (cur < 0) begin
      ttl = charge_mas / mag;
    end else begin
      room = (full_mas > charge_mas) ? full_mas - charge_mas : 64'd0;
      ttl  = room / mag;
    end

    // closed-circuit voltage in microvolts, then back to millivolts
    uv = $signed({48'd0, ocv_reg}) * 64'sd1000 + cur * $signed({48'd0, res_reg});
    if (uv < 0) begin
      vout = '0;
    end else begin
      vout = uv / 64'sd1000;
      if (vout > {47'd0, VOLT_MAX}) vout = {47'd0, VOLT_MAX};
    end

    r.soc_q16           = soc[SOC_W-1:0];
    r.remaining_charge  = charge_mas[CHG_W-1:0];
    r.energy_used       = energy_nj;
    r.time_to_limit_ms  = ttl[TTL_W-1:0];
    r.closed_voltage_mv = vout[VOLT_W-1:0];
    r.status            = fault;
    return r;
  endfunction

  // random step: zero current, raw noise, or a discharge/charge of random scale
  function automatic in_item_t make_step(input int kind);
    in_item_t         s;
    logic [31:0]      raw;
    logic [18:0]      mag;
    logic [15:0]      ms_raw;
    raw    = $urandom;
    ms_raw = $urandom;
    mag    = raw[18:0] >> $urandom_range(0, 19);
    case (kind)
      0:       s.port_current_ma = '0;
      1:       s.port_current_ma = raw[CUR_W-1:0];
      2:       s.port_current_ma = -$signed({1'b0, mag}) - 20'sd1;
      default: s.port_current_ma = $signed({1'b0, mag});
    endcase
    s.elapsed_ms = ms_raw >> $urandom_range(0, 16);
    return s;
  endfunction

  // directed step
  task automatic push_step(input int cur, input int ms);
    in_item_t s;
    s.port_current_ma = cur[CUR_W-1:0];
    s.elapsed_ms      = ms[MS_W-1:0];
    pending_steps.push_back(s);
  endtask

  // queue runs of same-direction steps with a little noise in between
  task automatic queue_random_steps(input int count);
    int queued;
    int run_len;
    int pick;
    int kind;
    queued = 0;
    while (queued < count) begin
      run_len = $urandom_range(1, 12);
      pick    = $urandom_range(0, 19);
      kind    = (pick == 0) ? 0 : (pick < 3) ? 1 : (pick < 12) ? 2 : 3;
      for (int i = 0; i < run_len && queued < count; i++) begin
        pending_steps.push_back(make_step(kind));
        queued++;
      end
    end
  endtask

  // wait until nothing is queued, offered or outstanding
  task automatic wait_quiet();
    while (pending_steps.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[REG_W-1:0];
    case (idx)
      REG_CAPACITY:   cap_reg = value[REG_W-1:0];
      REG_OPEN_MV:    ocv_reg = value[REG_W-1:0];
      REG_RESISTANCE: res_reg = value[REG_W-1:0];
      default: ;
    endcase
  endtask

  // one register setting: program, then two halves of random steps with a full drain between
  task automatic run_setting(input int cap, input int ocv, input int res, input int count,
                             input int mode, input bit hold);
    wait_quiet();
    case (mode)
      0: begin send_idle_pct = 10; recv_stall_pct = 48; end
      1: begin send_idle_pct = 48; recv_stall_pct = 10; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_OPEN_MV, ocv);
    write_reg(REG_RESISTANCE, res);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
    queue_random_steps(count / 2);
    if (hold) hold_requests++;
    wait_quiet();
    queue_random_steps(count - count / 2);
  endtask

  // compare one field of a reading
  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reading %0d: %s expected 0x%0h, got 0x%0h",
                 readings_checked, field, want_v, got_v);
    end
  endtask

  // driver: offer pending steps, predict each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_readings.push_back(advance_gauge(in_data_i));
        steps_taken++;
      end
      if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_steps.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check accepted readings and drive the output stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading %0d: unexpected transaction", readings_checked);
        end else begin
          want = expected_readings.pop_front();
          compare_field("soc_q16", 64'(want.soc_q16), 64'(out_data_o.soc_q16));
          compare_field("remaining_charge", 64'(want.remaining_charge),
                        64'(out_data_o.remaining_charge));
          compare_field("energy_used", want.energy_used, out_data_o.energy_used);
          compare_field("time_to_limit_ms", 64'(want.time_to_limit_ms),
                        64'(out_data_o.time_to_limit_ms));
          compare_field("closed_voltage_mv", 64'(want.closed_voltage_mv),
                        64'(out_data_o.closed_voltage_mv));
          compare_field("status", 64'(want.status), 64'(out_data_o.status));
        end
        readings_checked++;
      end

      // long hold-off on request, else random stalls
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycle_count, expected_readings.size());
      $display("tb_battery_coulomb_counter_unit: FAIL");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed steps at reset register values
    push_step(0, 0);
    push_step(0, 65535);
    push_step(-1, 1);
    push_step(1, 1);
    push_step(-524288, 0);
    push_step(524287, 0);
    // exactly empty or one past full first; the other limit follows with the status held
    empty_first = $urandom_range(0, 1);
    if (empty_first) begin
      push_step(-60000, 60000);
      push_step(-1, 1);
      push_step(524287, 65535);
    end else begin
      push_step(1, 1);
      push_step(-60000, 60000);
      push_step(-1, 1);
    end
    push_step(-1000, 3600);
    push_step(2000, 1800);
    push_step(-524288, 65535);
    push_step(524287, 65535);
    push_step(0, 1234);
    push_step(-7, 65535);
    push_step(13, 40000);
    push_step(-300000, 12345);

    // register settings: extremes, zero capacity, random ones
    run_setting(65535, 65535, 65535, 330, 0, 1'b1);
    run_setting(1, 1, 0, 330, 0, 1'b0);
    run_setting(0, 3300, 150, 150, 1, 1'b0);
    run_setting($urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(0, 65535), 330, 1, 1'b0);
    run_setting(2000, 65535, 65535, 330, 2, 1'b1);
    run_setting($urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(0, 65535), 330, 2, 1'b0);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d readings from %0d steps over %0d register settings",
             readings_checked, steps_taken, settings_run);
    $display("limit order: %s first, final status %0d, %0d mismatches",
             empty_first ? "empty" : "full", fault, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_battery_coulomb_counter_unit: PASS");
    end else begin
      $display("tb_battery_coulomb_counter_unit: FAIL");
    end
    $finish;
  end

endmodule
